>>> rtl/glos_pkg.sv
// Shared types and constants for the grid line-of-sight check.
package glos_pkg;

    // Field widths fixed by the request format
    localparam int COORD_W = 6;
    // Error term range is about +/-126 for 6-bit coordinates
    localparam int ERR_W   = 9;
    // Tile count of a walk: 1 + dx + dy, at most 127
    localparam int LEFT_W  = 7;

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } glos_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;  // write zero at clear counter, advance it
        logic wall_wr;   // write the requested wall bit
        logic load;      // load walk registers from the request
        logic issue;     // read current tile, step to next
        logic finish;    // register the result and strobe it
    } glos_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;  // clear counter at last entry
        logic walk_last; // current tile is the last of the walk
        logic hit;       // tile read last cycle is a wall
    } glos_status_t;

endpackage

>>> rtl/glos_ram.sv
// Generic single-write, single-read RAM with registered read data.
module glos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/glos_ctrl.sv
// Controller state machine: clearing pass, request dispatch and walk sequencing.
module glos_ctrl
    import glos_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         req_type,
    input  glos_status_t st,
    output glos_cmd_t    cmd,
    output logic         busy
);

    glos_state_t state_reg;
    glos_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (req_type == REQ_WRITE)
                    begin
                        cmd.wall_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // stop at the first wall found
                if (st.hit)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.issue = 1'b1;
                    if (st.walk_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                // last tile's read data is back
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An accepted query always holds the block busy next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_QUERY) |=> busy)
        else $error("query accepted but block not busy");

    // Results are only produced from the walk or the drain step
    a_finish_src: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (state_reg == ST_WALK || state_reg == ST_DRAIN))
        else $error("finish outside of a walk");

endmodule

>>> rtl/glos_dp.sv
// Datapath: wall map, clear counter, line walker and result register.
module glos_dp
    import glos_pkg::*;
#(
    parameter int GRID_SIDE = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  glos_cmd_t          cmd,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic               wall_bit,
    output glos_status_t       st,
    output logic               done,
    output logic               path_clear
);

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);

    function automatic logic [ADDR_W-1:0] tile_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
        return ADDR_W'(y) * ADDR_W'(GRID_SIDE) + ADDR_W'(x);
    endfunction

    function automatic logic tile_in_map(input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y);
        return (int'(x) < GRID_SIDE) && (int'(y) < GRID_SIDE);
    endfunction

    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic [COORD_W-1:0]       x_reg;
    logic [COORD_W-1:0]       y_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic [COORD_W-1:0]       dx_reg;
    logic [COORD_W-1:0]       dy_reg;
    logic                     x_inc_reg;
    logic                     y_inc_reg;
    logic [LEFT_W-1:0]        left_reg;
    logic                     rd_valid_reg;
    logic                     rd_inmap_reg;
    logic                     done_reg;
    logic                     path_clear_reg;

    logic [COORD_W-1:0]       dx_next;
    logic [COORD_W-1:0]       dy_next;
    logic signed [ERR_W-1:0]  dx2;
    logic signed [ERR_W-1:0]  dy2;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [0:0]               ram_wdata;
    logic [0:0]               ram_rdata;
    logic                     hit;

    // Wall map write port: clearing pass or a single tile write
    always_comb
    begin
        if (cmd.clear_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = 1'b0;
        end
        else
        begin
            ram_we    = cmd.wall_wr && tile_in_map(start_x, start_y);
            ram_waddr = tile_addr(start_x, start_y);
            ram_wdata = wall_bit;
        end
    end

    glos_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_wall_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (tile_addr(x_reg, y_reg)),
        .rdata (ram_rdata)
    );

    // Clear counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Absolute differences of the query
    assign dx_next = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
    assign dy_next = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
    assign dx2     = signed'(ERR_W'({dx_reg, 1'b0}));
    assign dy2     = signed'(ERR_W'({dy_reg, 1'b0}));

    // Walker: one tile per issue
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= start_x;
            y_reg     <= start_y;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            x_inc_reg <= end_x > start_x;
            y_inc_reg <= end_y > start_y;
            err_reg   <= signed'(ERR_W'(dx_next)) - signed'(ERR_W'(dy_next));
            left_reg  <= LEFT_W'(dx_next) + LEFT_W'(dy_next) + 1'b1;
        end
        else if (cmd.issue)
        begin
            left_reg <= left_reg - 1'b1;
            if (err_reg > 0)
            begin
                x_reg   <= x_inc_reg ? x_reg + 1'b1 : x_reg - 1'b1;
                err_reg <= err_reg - dy2;
            end
            else
            begin
                y_reg   <= y_inc_reg ? y_reg + 1'b1 : y_reg - 1'b1;
                err_reg <= err_reg + dx2;
            end
        end
    end

    // Read tracking, lines up with registered RAM data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_inmap_reg <= tile_in_map(x_reg, y_reg);
    end

    // Off-map tiles read as open
    assign hit = rd_valid_reg && rd_inmap_reg && ram_rdata[0];

    // Result register, one-cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            path_clear_reg <= !hit;
        end
    end

    assign st.clr_last  = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign st.walk_last = (left_reg == LEFT_W'(1));
    assign st.hit       = hit;
    assign done         = done_reg;
    assign path_clear   = path_clear_reg;

    // The walker never reads past the tile count
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (left_reg != '0))
        else $error("walk issued past last tile");

    // Map writes and walk reads never share a cycle
    a_wr_rd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && cmd.issue))
        else $error("wall map write during walk");

    // A new walk starts with no stale read pending
    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !rd_valid_reg)
        else $error("stale read at walk start");

endmodule

>>> rtl/grid_line_of_sight_check.sv
// Transactions: a tile write is done in the idle state; a query walks at most 1 + dx + dy
// tiles, stops early at the first wall, and then strobes done.
// Throughput: one transaction at a time; a write every cycle while idle, and one
// wall-map read per cycle while walking.
// Reset: a clearing pass writes all GRID_SIDE*GRID_SIDE tiles (4096 by default) open,
// with busy high; done strobes for one cycle and cannot be stalled.
module grid_line_of_sight_check
    import glos_pkg::*;
#(
    parameter int GRID_SIDE = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic               wall_bit,
    output logic               done,
    output logic               path_clear
);

    glos_cmd_t    cmd;
    glos_status_t st;

    glos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .st       (st),
        .cmd      (cmd),
        .busy     (busy)
    );

    glos_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .wall_bit   (wall_bit),
        .st         (st),
        .done       (done),
        .path_clear (path_clear)
    );

endmodule
